// ===== hdl/car_pkg.sv =====
`default_nettype none

package car_pkg;

	localparam int RATE_W = 32;

	typedef logic [RATE_W-1:0] rate_t;

	// 1.0 in Q2.30 and pi in Q2.30
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	typedef enum logic [1:0] {
		REG_MAX_RATE   = 2'd0,
		REG_MIN_RATE   = 2'd1,
		REG_EPOCH_SPAN = 2'd2
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== hdl/car_div.sv =====
`default_nettype none

module car_div #(
	parameter int EW = 32,
	parameter int PHASE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_vld,
	input  wire logic [EW-1:0]         in_rem,
	input  wire logic                  in_zero,
	input  wire logic [EW-1:0]         span,
	output logic                       out_vld,
	output logic [PHASE_BITS:0]        out_quo,
	output logic                       out_zero
);

	localparam int STEPS = PHASE_BITS + 1;

	// entry k is the register after step k-1
	logic                vld_s  [1:STEPS];
	logic                zero_s [1:STEPS];
	logic [EW-1:0]       rem_s  [1:STEPS];
	logic [PHASE_BITS:0] quo_s  [1:STEPS];

	logic [EW-1:0]       rem_nx [STEPS];
	logic [PHASE_BITS:0] quo_nx [STEPS];

	// one quotient bit a stage, most significant first
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [EW:0]         trial;
		logic [PHASE_BITS:0] quo_in;
		logic [EW:0]         diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign trial  = {1'b0, in_rem};
			assign quo_in = '0;
		end else begin : g_rest
			assign trial  = {rem_s[k], 1'b0};
			assign quo_in = quo_s[k];
		end

		assign diff      = trial - {1'b0, span};
		assign ge        = trial >= {1'b0, span};
		assign rem_nx[k] = ge ? diff[EW-1:0] : trial[EW-1:0];
		assign quo_nx[k] = {quo_in[PHASE_BITS-1:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= STEPS; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int k = 1; k < STEPS; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[1] <= in_zero;
			for (int k = 1; k < STEPS; k++) begin
				zero_s[k+1] <= zero_s[k];
			end
			for (int k = 0; k < STEPS; k++) begin
				rem_s[k+1] <= rem_nx[k];
				quo_s[k+1] <= quo_nx[k];
			end
		end
	end

	assign out_vld  = vld_s[STEPS];
	assign out_quo  = quo_s[STEPS];
	assign out_zero = zero_s[STEPS];

endmodule

`default_nettype wire

// ===== hdl/car_cos.sv =====
`default_nettype none

module car_cos
	import car_pkg::*;
#(
	parameter int PHASE_BITS = 16,
	parameter int COS_TABLE_ENTRIES = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_vld,
	input  wire logic [PHASE_BITS:0]   in_quo,
	input  wire logic                  in_zero,
	output logic                       out_vld,
	output logic [31:0]                out_term
);

	localparam int NW    = $clog2(COS_TABLE_ENTRIES + 1);
	localparam int TWO_N = 2 * COS_TABLE_ENTRIES;
	localparam logic [PHASE_BITS:0] FULL = {1'b1, {PHASE_BITS{1'b0}}};
	localparam logic [PHASE_BITS:0] HALF = {2'b01, {(PHASE_BITS-1){1'b0}}};
	localparam logic [NW-1:0] N_C = NW'(COS_TABLE_ENTRIES);

	// denominators (2n-1)*2n of the series terms
	localparam logic [63:0] TAYLOR_DIV [10] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	typedef logic [30:0] rom_t [COS_TABLE_ENTRIES+1];

	// Taylor series in Q30, truncating products, clamped to [0, 1]
	function automatic logic [30:0] cos_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        t;
		logic signed [65:0] sum;
		x2  = (x * x) >> 30;
		t   = 64'(ONE_Q30);
		sum = 66'(ONE_Q30);
		for (int n = 1; n <= 10; n++) begin
			t = ((t * x2) >> 30) / TAYLOR_DIV[n-1];
			if (n % 2 == 1) begin
				sum = sum - $signed({2'b00, t});
			end else begin
				sum = sum + $signed({2'b00, t});
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed(66'(ONE_Q30))) begin
			sum = 66'(ONE_Q30);
		end
		return sum[30:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
			x    = (PI_Q30 * 64'(k)) / TWO_N;
			r[k] = cos_q30(x);
		end
		r[COS_TABLE_ENTRIES] = '0;
		return r;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic                  upper_s1, upper_s2, upper_s3;
	logic [PHASE_BITS-1:0] phase_s1;
	logic [NW-1:0]         idx_s2;
	logic [30:0]           cos_s3;
	logic [31:0]           term_s4;

	logic [PHASE_BITS:0]      ratio;
	logic                     upper;
	logic [PHASE_BITS:0]      fold;
	logic [PHASE_BITS+NW-1:0] scaled;

	// fold the upper half of the phase onto the quarter wave
	assign ratio  = in_zero ? FULL : in_quo;
	assign upper  = ratio > HALF;
	assign fold   = upper ? FULL - ratio : ratio;
	assign scaled = {{NW{1'b0}}, phase_s1} * {{PHASE_BITS{1'b0}}, N_C};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			upper_s1 <= upper;
			phase_s1 <= fold[PHASE_BITS-1:0];
			upper_s2 <= upper_s1;
			idx_s2   <= scaled[PHASE_BITS-1 +: NW];
			upper_s3 <= upper_s2;
			cos_s3   <= COS_ROM[idx_s2];
			term_s4  <= upper_s3 ? ONE_Q30 - {1'b0, cos_s3} : ONE_Q30 + {1'b0, cos_s3};
		end
	end

	assign out_vld  = vld_s4;
	assign out_term = term_s4;

endmodule

`default_nettype wire

// ===== hdl/car_mul.sv =====
`default_nettype none

module car_mul
	import car_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_vld,
	input  wire logic [31:0] in_term,
	input  wire rate_t       diff,
	input  wire rate_t       min_rate,
	input  wire logic        bad,
	output logic             out_vld,
	output rate_t            out_rate,
	output logic             out_bad
);

	logic        vld_s1, vld_s2, vld_s3;
	logic [63:0] prod_s1;
	logic [32:0] step_s2;
	rate_t       rate_s3;
	logic        bad_s3;

	logic [63:0] rounded;

	// round half up, then drop 31 bits: the 30 fraction bits of the term and one more to halve it
	assign rounded = prod_s1 + 64'h4000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {32'd0, diff} * {32'd0, in_term};
			step_s2 <= rounded[63:31];
			rate_s3 <= bad ? '0 : min_rate + step_s2[RATE_W-1:0];
			bad_s3  <= bad;
		end
	end

	assign out_vld  = vld_s3;
	assign out_rate = rate_s3;
	assign out_bad  = bad_s3;

endmodule

`default_nettype wire

// ===== hdl/cosine_annealing_rate.sv =====
// An accepted epoch passes the input register, the one-bit-a-stage divider, the cosine
// stages, the multiplier stages and the output buffer head before its rate can be taken.
// Throughput: one item per cycle while in_stall is low; a two-entry output buffer keeps
// the pipeline moving after the output stalls until its spare entry fills, and in_stall
// is a registered signal.
// Reset: asynchronous, active low; clears all valid bits and loads the register defaults.
`default_nettype none

module cosine_annealing_rate
	import car_pkg::*;
#(
	parameter int EPOCH_BITS = 32,
	parameter int PHASE_BITS = 16,
	parameter int COS_TABLE_ENTRIES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] epoch,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      rate,
	output logic             bad_config
);

	localparam int EW = (EPOCH_BITS < 32) ? EPOCH_BITS : 32;

	rate_t max_rate_q, min_rate_q;
	logic [31:0] epoch_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q   <= 32'd26843546;
			min_rate_q   <= 32'd268435;
			epoch_span_q <= 32'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_RATE:   max_rate_q   <= cfg_data;
				REG_MIN_RATE:   min_rate_q   <= cfg_data;
				REG_EPOCH_SPAN: epoch_span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_vld_q, head_vld_q;
	rate_t skid_rate_q, head_rate_q;
	logic skid_bad_q, head_bad_q;

	// the whole pipeline holds only while the spare output entry is full
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	logic [EW-1:0] span;
	logic [EW-1:0] ep;
	logic          vld_s1;
	logic [EW-1:0] ep_s1;
	logic          zero_s1;

	assign span = epoch_span_q[EW-1:0];
	assign ep   = epoch[EW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	// saturate the epoch at the span
	always_ff @(posedge clk) begin
		if (en) begin
			ep_s1   <= (ep > span) ? span : ep;
			zero_s1 <= span == '0;
		end
	end

	logic                div_vld;
	logic [PHASE_BITS:0] div_quo;
	logic                div_zero;

	car_div #(
		.EW(EW),
		.PHASE_BITS(PHASE_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s1),
		.in_rem(ep_s1),
		.in_zero(zero_s1),
		.span(span),
		.out_vld(div_vld),
		.out_quo(div_quo),
		.out_zero(div_zero)
	);

	logic        cos_vld;
	logic [31:0] anneal_term;

	car_cos #(
		.PHASE_BITS(PHASE_BITS),
		.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
	) u_cos (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(div_vld),
		.in_quo(div_quo),
		.in_zero(div_zero),
		.out_vld(cos_vld),
		.out_term(anneal_term)
	);

	logic  mul_vld;
	rate_t mul_rate;
	logic  mul_bad;

	car_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(cos_vld),
		.in_term(anneal_term),
		.diff(max_rate_q - min_rate_q),
		.min_rate(min_rate_q),
		.bad(min_rate_q > max_rate_q),
		.out_vld(mul_vld),
		.out_rate(mul_rate),
		.out_bad(mul_bad)
	);

	logic take;
	logic push;

	assign take = head_vld_q && !out_stall;
	assign push = en && mul_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!head_vld_q || take) begin
				head_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			head_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				head_rate_q <= skid_rate_q;
				head_bad_q  <= skid_bad_q;
			end
		end else if (push) begin
			if (!head_vld_q || take) begin
				head_rate_q <= mul_rate;
				head_bad_q  <= mul_bad;
			end else begin
				skid_rate_q <= mul_rate;
				skid_bad_q  <= mul_bad;
			end
		end
	end

	assign out_valid  = head_vld_q;
	assign rate       = head_rate_q;
	assign bad_config = head_bad_q;

	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> head_vld_q)
		else $error("spare output entry full while the head is empty");

	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_config) |-> (rate == '0))
		else $error("rate not zero on a bad configuration");

	a_frozen_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && mul_vld) |=> (mul_vld && $stable(mul_rate)))
		else $error("last pipeline item lost while the output buffer was full");

endmodule

`default_nettype wire
